[rtl/stl_pkg.sv]
package stl_pkg;

    localparam int EXP_TABLE_DEPTH = 256;
    localparam int K_W             = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_W           = 17;
    localparam int RECIP_W         = K_W + 29;
    localparam int RL_W            = 18;
    localparam int RH_W            = RECIP_W - RL_W;
    localparam int Q_W             = 23;
    localparam int PROD_W          = Q_W + RECIP_W + 1;
    localparam int P_W             = Q_W + RECIP_W - 24;
    localparam int FRAC_W          = 16;
    localparam int CFG_W           = 8;
    localparam int CFG_IDX_W       = 2;

    localparam logic [7:0]  SAT_PICK_RESET = 8'd128;
    localparam logic [7:0]  SIGMA_RESET    = 8'd20;
    // Saturation distance: x/100 for x < 25600 is (x * 20972) >> 21.
    localparam logic [14:0] SD_RECIP       = 15'd20972;
    localparam logic [15:0] SD_SAT_LIMIT   = 16'd25550;

    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_PICK = 2'd0,
        CFG_SAT_PICK = 2'd1,
        CFG_SIGMA    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [7:0]    hue_pick;
        logic [7:0]           sat_pick;
        logic [RECIP_W-1:0]   recip;
        logic                 sig_zero;
    } t_cfg;

    typedef logic [EXP_W-1:0]   t_exp_lut [EXP_TABLE_DEPTH];
    typedef logic [RECIP_W-1:0] t_recip_tab [256];

    // Shift-subtract division, used only while building constant tables.
    function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-f) for f in [0,1] in Q30 from an alternating Taylor series.
    function automatic longint unsigned exp_neg_frac(longint unsigned f);
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned term;
        longint unsigned kk;
        pos  = ONE_Q30;
        neg  = 64'd0;
        term = ONE_Q30;
        for (int k = 1; k <= 20; k++) begin
            kk   = longint'(k);
            term = udiv64(term * f + (kk << 29), kk << 30);
            if (k % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return pos - neg;
    endfunction

    // Entry i holds exp(-i*8/depth) in Q16; with diff_sel it holds the drop to entry i+1.
    function automatic t_exp_lut exp_lut(bit diff_sel);
        t_exp_lut        lut;
        longint unsigned e1;
        longint unsigned x;
        longint unsigned f;
        longint unsigned en;
        longint unsigned full [EXP_TABLE_DEPTH+1];
        int              n;
        e1 = exp_neg_frac(ONE_Q30);
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            x  = (longint'(i) << 33) / EXP_TABLE_DEPTH;
            n  = int'(x >> 30);
            f  = x & (ONE_Q30 - 64'd1);
            en = ONE_Q30;
            for (int j = 0; j < n; j++) begin
                en = (en * e1 + (ONE_Q30 >> 1)) >> 30;
            end
            full[i] = (en * exp_neg_frac(f) + (64'd1 << 43)) >> 44;
        end
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            if (diff_sel) begin
                lut[i] = (full[i] > full[i+1]) ? EXP_W'(full[i] - full[i+1]) : '0;
            end else begin
                lut[i] = EXP_W'(full[i]);
            end
        end
        return lut;
    endfunction

    // Reciprocal of 800*sigma^2 scaled so the product lands in table steps, Q16.
    function automatic t_recip_tab recip_table();
        t_recip_tab      tab;
        longint unsigned d;
        for (int sw = 0; sw < 256; sw++) begin
            d = 64'd800 * longint'(sw) * longint'(sw);
            if (d == 64'd0) begin
                tab[sw] = '0;
            end else begin
                tab[sw] = RECIP_W'(udiv64((longint'(EXP_TABLE_DEPTH) << 37) + (d >> 1), d));
            end
        end
        return tab;
    endfunction

    localparam t_exp_lut   EXP_BASE  = exp_lut(1'b0);
    localparam t_exp_lut   EXP_DIFF  = exp_lut(1'b1);
    localparam t_recip_tab RECIP_TAB = recip_table();

endpackage

[rtl/stl_cfg.sv]
module stl_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stl_pkg::CFG_W-1:0]     i_cfg_data,
    output stl_pkg::t_cfg                 o_cfg
);

    logic signed [7:0]             r_hue_pick;
    logic [7:0]                    r_sat_pick;
    logic [stl_pkg::RECIP_W-1:0]   r_recip;
    logic                          r_sig_zero;

    // The reciprocal comes from a constant table, so a new width is usable at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_pick <= '0;
            r_sat_pick <= stl_pkg::SAT_PICK_RESET;
            r_recip    <= stl_pkg::RECIP_TAB[stl_pkg::SIGMA_RESET];
            r_sig_zero <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                stl_pkg::CFG_HUE_PICK: begin
                    r_hue_pick <= $signed(i_cfg_data);
                end
                stl_pkg::CFG_SAT_PICK: begin
                    r_sat_pick <= i_cfg_data;
                end
                stl_pkg::CFG_SIGMA: begin
                    r_recip    <= stl_pkg::RECIP_TAB[i_cfg_data];
                    r_sig_zero <= (i_cfg_data == 8'd0);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.hue_pick = r_hue_pick;
    assign o_cfg.sat_pick = r_sat_pick;
    assign o_cfg.recip    = r_recip;
    assign o_cfg.sig_zero = r_sig_zero;

endmodule

[rtl/stl_dist.sv]
module stl_dist (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  stl_pkg::t_cfg             i_cfg,
    input  logic                      i_vld,
    output logic                      o_rdy,
    input  logic [7:0]                i_hue,
    input  logic [7:0]                i_sat,
    output logic                      o_vld,
    input  logic                      i_rdy,
    output logic [stl_pkg::Q_W-1:0]   o_q,
    output logic [7:0]                o_hd,
    output logic [7:0]                o_sd,
    output logic                      o_force_zero
);

    logic signed [8:0]  w_h;
    logic signed [9:0]  w_d;
    logic signed [8:0]  w_s;
    logic signed [19:0] w_d2f;
    logic signed [17:0] w_s2f;
    logic               w_rdy1;
    logic               w_rdy2;

    logic               r1_vld;
    logic [15:0]        r1_d2;
    logic [15:0]        r1_s2;

    logic [16:0]        w_hd_sum;
    logic [14:0]        w_hd_q;
    logic [14:0]        w_sd_x;
    logic [29:0]        w_sd_m;
    logic [7:0]         w_hd;
    logic [7:0]         w_sd;
    logic [stl_pkg::Q_W-1:0] w_q;

    logic               r2_vld;
    logic [stl_pkg::Q_W-1:0] r2_q;
    logic [7:0]         r2_hd;
    logic [7:0]         r2_sd;
    logic               r2_fz;

    assign w_rdy2 = !r2_vld || i_rdy;
    assign w_rdy1 = !r1_vld || w_rdy2;
    assign o_rdy  = w_rdy1;

    // Stage 1: hue wrap, differences and squares.
    assign w_h   = (i_hue > 8'd90) ? $signed({1'b0, i_hue}) - 9'sd180
                                   : $signed({1'b0, i_hue});
    assign w_d   = $signed({w_h[8], w_h}) - $signed({{2{i_cfg.hue_pick[7]}}, i_cfg.hue_pick});
    assign w_s   = $signed({1'b0, i_sat}) - $signed({1'b0, i_cfg.sat_pick});
    assign w_d2f = w_d * w_d;
    assign w_s2f = w_s * w_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_rdy1) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_d2 <= w_d2f[15:0];
            r1_s2 <= w_s2f[15:0];
        end
    end

    // Stage 2: rounded squared distances and the exact sum scaled by 400.
    assign w_hd_sum = {1'b0, r1_d2} + 17'd2;
    assign w_hd_q   = w_hd_sum[16:2];
    assign w_hd     = (w_hd_q > 15'd255) ? 8'hFF : w_hd_q[7:0];

    assign w_sd_x   = r1_s2[14:0] + 15'd50;
    assign w_sd_m   = {15'd0, w_sd_x} * {15'd0, stl_pkg::SD_RECIP};
    assign w_sd     = (r1_s2 >= stl_pkg::SD_SAT_LIMIT) ? 8'hFF : w_sd_m[28:21];

    assign w_q      = stl_pkg::Q_W'({r1_d2, 6'd0}) + stl_pkg::Q_W'({r1_d2, 5'd0})
                    + stl_pkg::Q_W'({r1_d2, 2'd0}) + stl_pkg::Q_W'({r1_s2, 2'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_rdy2) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_q  <= w_q;
            r2_hd <= w_hd;
            r2_sd <= w_sd;
            r2_fz <= i_cfg.sig_zero && ((r1_d2 != 16'd0) || (r1_s2 != 16'd0));
        end
    end

    assign o_vld        = r2_vld;
    assign o_q          = r2_q;
    assign o_hd         = r2_hd;
    assign o_sd         = r2_sd;
    assign o_force_zero = r2_fz;

endmodule

[rtl/stl_scale.sv]
module stl_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  stl_pkg::t_cfg               i_cfg,
    input  logic                        i_vld,
    output logic                        o_rdy,
    input  logic [stl_pkg::Q_W-1:0]     i_q,
    input  logic [7:0]                  i_hd,
    input  logic [7:0]                  i_sd,
    input  logic                        i_force_zero,
    output logic                        o_vld,
    input  logic                        i_rdy,
    output logic [stl_pkg::K_W-1:0]     o_k,
    output logic [stl_pkg::FRAC_W-1:0]  o_frac,
    output logic                        o_kill,
    output logic [7:0]                  o_hd,
    output logic [7:0]                  o_sd
);

    localparam logic [stl_pkg::PROD_W-1:0] ROUND = stl_pkg::PROD_W'(1) << 23;

    logic                                 w_rdy3;
    logic                                 w_rdy4;

    logic                                 r3_vld;
    logic [stl_pkg::Q_W+stl_pkg::RL_W-1:0] r3_pl;
    logic [stl_pkg::Q_W+stl_pkg::RH_W-1:0] r3_ph;
    logic [7:0]                           r3_hd;
    logic [7:0]                           r3_sd;
    logic                                 r3_fz;

    logic [stl_pkg::PROD_W-1:0]           w_prod;
    logic [stl_pkg::P_W-1:0]              w_p;

    logic                                 r4_vld;
    logic [stl_pkg::K_W-1:0]              r4_k;
    logic [stl_pkg::FRAC_W-1:0]           r4_frac;
    logic                                 r4_kill;
    logic [7:0]                           r4_hd;
    logic [7:0]                           r4_sd;

    assign w_rdy4 = !r4_vld || i_rdy;
    assign w_rdy3 = !r3_vld || w_rdy4;
    assign o_rdy  = w_rdy3;

    // Stage 3: the wide product is split in two partial products on the reciprocal.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_rdy3) begin
            r3_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_pl <= {{stl_pkg::RL_W{1'b0}}, i_q}
                   * {{stl_pkg::Q_W{1'b0}}, i_cfg.recip[stl_pkg::RL_W-1:0]};
            r3_ph <= {{stl_pkg::RH_W{1'b0}}, i_q}
                   * {{stl_pkg::Q_W{1'b0}}, i_cfg.recip[stl_pkg::RECIP_W-1:stl_pkg::RL_W]};
            r3_hd <= i_hd;
            r3_sd <= i_sd;
            r3_fz <= i_force_zero;
        end
    end

    // Stage 4: combine, round to the Q16 table position, check the table range.
    assign w_prod = stl_pkg::PROD_W'({r3_ph, {stl_pkg::RL_W{1'b0}}})
                  + stl_pkg::PROD_W'(r3_pl) + ROUND;
    assign w_p    = w_prod[24 +: stl_pkg::P_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_rdy4) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r4_k    <= w_p[stl_pkg::FRAC_W +: stl_pkg::K_W];
            r4_frac <= w_p[stl_pkg::FRAC_W-1:0];
            r4_kill <= r3_fz || (|w_p[stl_pkg::P_W-1:stl_pkg::FRAC_W+stl_pkg::K_W]);
            r4_hd   <= r3_hd;
            r4_sd   <= r3_sd;
        end
    end

    assign o_vld  = r4_vld;
    assign o_k    = r4_k;
    assign o_frac = r4_frac;
    assign o_kill = r4_kill;
    assign o_hd   = r4_hd;
    assign o_sd   = r4_sd;

endmodule

[rtl/stl_exp.sv]
module stl_exp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    output logic                        o_rdy,
    input  logic [stl_pkg::K_W-1:0]     i_k,
    input  logic [stl_pkg::FRAC_W-1:0]  i_frac,
    input  logic                        i_kill,
    input  logic [7:0]                  i_hd,
    input  logic [7:0]                  i_sd,
    output logic                        o_vld,
    input  logic                        i_rdy,
    output logic [7:0]                  o_hd,
    output logic [7:0]                  o_sd,
    output logic [7:0]                  o_lik
);

    localparam int M_W = stl_pkg::EXP_W + stl_pkg::FRAC_W;

    logic                          w_rdy5;
    logic                          w_rdy6;

    logic                          r5_vld;
    logic [stl_pkg::EXP_W-1:0]     r5_a;
    logic [M_W-1:0]                r5_m;
    logic                          r5_kill;
    logic [7:0]                    r5_hd;
    logic [7:0]                    r5_sd;

    logic [M_W:0]                  w_m_rnd;
    logic [stl_pkg::EXP_W-1:0]     w_v;
    logic [stl_pkg::EXP_W+8:0]     w_l_sum;
    logic [9:0]                    w_l;
    logic [7:0]                    w_lik;

    logic                          r6_vld;
    logic [7:0]                    r6_hd;
    logic [7:0]                    r6_sd;
    logic [7:0]                    r6_lik;

    assign w_rdy6 = !r6_vld || i_rdy;
    assign w_rdy5 = !r5_vld || w_rdy6;
    assign o_rdy  = w_rdy5;

    // Stage 5: table lookup and the interpolation product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_rdy5) begin
            r5_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r5_a    <= stl_pkg::EXP_BASE[i_k];
            r5_m    <= {{stl_pkg::FRAC_W{1'b0}}, stl_pkg::EXP_DIFF[i_k]}
                     * {{stl_pkg::EXP_W{1'b0}}, i_frac};
            r5_kill <= i_kill;
            r5_hd   <= i_hd;
            r5_sd   <= i_sd;
        end
    end

    // Stage 6: interpolated value, scaled by 255 with rounding.
    assign w_m_rnd = {1'b0, r5_m} + (M_W+1)'(32'h8000);
    assign w_v     = r5_a - stl_pkg::EXP_W'(w_m_rnd[M_W:stl_pkg::FRAC_W]);
    assign w_l_sum = {w_v, 8'd0} - {8'd0, w_v} + (stl_pkg::EXP_W+8)'(32'h8000);
    assign w_l     = w_l_sum[stl_pkg::EXP_W+8:16];
    assign w_lik   = r5_kill ? 8'd0 : ((w_l > 10'd255) ? 8'hFF : w_l[7:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_rdy6) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy6) begin
            r6_hd  <= r5_hd;
            r6_sd  <= r5_sd;
            r6_lik <= w_lik;
        end
    end

    assign o_vld = r6_vld;
    assign o_hd  = r6_hd;
    assign o_sd  = r6_sd;
    assign o_lik = r6_lik;

endmodule

[rtl/skin_tone_likelihood.sv]
// An accepted request passes the stage registers r1 to r5 and leaves from the output register r6.
// Throughput: one pixel per clock unless the output stalls; each of six register stages
// loads when empty or when the next one moves, so an output stall fills empty ones first.
// Reset (synchronous, active low) empties all stages and loads hue_pick 0, sat_pick 128
// and sigma_width 20; a sigma_width write looks up its reciprocal in the same cycle.
module skin_tone_likelihood (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_hue,
    input  logic [7:0]                    i_saturation,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_hue_dist_sq,
    output logic [7:0]                    o_sat_dist_sq,
    output logic [7:0]                    o_likelihood,
    input  logic                          i_cfg_we,
    input  logic [stl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stl_pkg::CFG_W-1:0]     i_cfg_data
);

    stl_pkg::t_cfg                  w_cfg;

    logic                           w_in_rdy;
    logic                           w_d_vld;
    logic                           w_d_rdy;
    logic [stl_pkg::Q_W-1:0]        w_d_q;
    logic [7:0]                     w_d_hd;
    logic [7:0]                     w_d_sd;
    logic                           w_d_fz;

    logic                           w_s_vld;
    logic                           w_s_rdy;
    logic [stl_pkg::K_W-1:0]        w_s_k;
    logic [stl_pkg::FRAC_W-1:0]     w_s_frac;
    logic                           w_s_kill;
    logic [7:0]                     w_s_hd;
    logic [7:0]                     w_s_sd;

    stl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    stl_dist u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_vld        (i_valid),
        .o_rdy        (w_in_rdy),
        .i_hue        (i_hue),
        .i_sat        (i_saturation),
        .o_vld        (w_d_vld),
        .i_rdy        (w_d_rdy),
        .o_q          (w_d_q),
        .o_hd         (w_d_hd),
        .o_sd         (w_d_sd),
        .o_force_zero (w_d_fz)
    );

    stl_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_vld        (w_d_vld),
        .o_rdy        (w_d_rdy),
        .i_q          (w_d_q),
        .i_hd         (w_d_hd),
        .i_sd         (w_d_sd),
        .i_force_zero (w_d_fz),
        .o_vld        (w_s_vld),
        .i_rdy        (w_s_rdy),
        .o_k          (w_s_k),
        .o_frac       (w_s_frac),
        .o_kill       (w_s_kill),
        .o_hd         (w_s_hd),
        .o_sd         (w_s_sd)
    );

    stl_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_s_vld),
        .o_rdy   (w_s_rdy),
        .i_k     (w_s_k),
        .i_frac  (w_s_frac),
        .i_kill  (w_s_kill),
        .i_hd    (w_s_hd),
        .i_sd    (w_s_sd),
        .o_vld   (o_valid),
        .i_rdy   (!i_stall),
        .o_hd    (o_hue_dist_sq),
        .o_sd    (o_sat_dist_sq),
        .o_lik   (o_likelihood)
    );

    assign o_stall = !w_in_rdy;

endmodule

[rtl/stl_chk.sv]
module stl_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [7:0]                    i_hue,
    input logic [7:0]                    i_saturation,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [7:0]                    o_hue_dist_sq,
    input logic [7:0]                    o_sat_dist_sq,
    input logic [7:0]                    o_likelihood,
    input logic                          i_cfg_we,
    input logic [stl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [stl_pkg::CFG_W-1:0]     i_cfg_data
);

    // A stalled result stays and keeps its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hue_dist_sq)
            && $stable(o_sat_dist_sq) && $stable(o_likelihood))
        else $error("stalled result changed");

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // The input side is only held off when every stage is full behind a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while the pipeline can move");

    // A result leaves only when it was taken.
    a_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) && $past(i_rst_n) |-> $past(!i_stall))
        else $error("result dropped without being taken");

endmodule

bind skin_tone_likelihood stl_chk u_stl_chk (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic [7:0] hue_sq;
        logic [7:0] sat_sq;
        logic [7:0] lik;
    } t_skin_score;

    typedef struct packed {
        bit          known;
        t_skin_score score;
    } t_typed_score;

    typedef struct packed {
        bit          is_reg;
        logic [1:0]  reg_idx;
        logic [7:0]  reg_data;
        logic [7:0]  hue;
        logic [7:0]  sat;
        bit          known;
        t_skin_score score;
    } t_dir_row;

    localparam int         TABLE_DEPTH   = stl_pkg::EXP_TABLE_DEPTH;
    localparam int         STUCK_LIMIT   = 4000;
    localparam int         HOLD_CYCLES   = 200;
    localparam int         PHASES        = 10;
    localparam int         PHASE_ITEMS   = 104;
    localparam int         DRAIN_CYCLES  = 8;
    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;
    localparam t_u64       Q30_UNIT      = t_u64'(1) << 30;
    localparam bit         PX = 1'b0;
    localparam bit         RG = 1'b1;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic [7:0]                        i_hue;
    logic [7:0]                        i_saturation;
    logic                              o_valid;
    logic                              i_stall;
    logic [7:0]                        o_hue_dist_sq;
    logic [7:0]                        o_sat_dist_sq;
    logic [7:0]                        o_likelihood;
    logic                              i_cfg_we;
    logic [stl_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [stl_pkg::CFG_W-1:0]         i_cfg_data;

    // Shadow of the block's registers, kept by the checker from sampled writes.
    int          hue_ref;
    int          sat_ref;
    int          sigma_ref;
    t_u64        recip_ref;
    t_u64        exp_q16 [0:TABLE_DEPTH];

    t_skin_score  pending_scores [$];
    t_typed_score typed_rows [$];
    int           mismatch_count = 0;
    bit           quiet_mode = 1'b0;
    bit           hold_trigger = 1'b0;
    bit           hold_taken = 1'b0;

    // Pixel rows with known set carry results that follow directly from the
    // register values; the rest go through the predictor.
    t_dir_row directed_rows [27] = '{
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd0,   8'd128, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd180, 8'd128, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd90,  8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd91,  8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd179, 8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd0,   8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd0,   8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd45,  8'd100, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{RG, stl_pkg::CFG_SIGMA,     8'd0,  8'd0,   8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd0,   8'd128, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd1,   8'd128, 1'b1, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd0,   8'd129, 1'b1, '{8'd0,   8'd0,   8'd0}},
        '{RG, stl_pkg::CFG_SIGMA,     8'd1,  8'd0,   8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd90,  8'd0,   1'b1, '{8'd255, 8'd164, 8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd0,   8'd128, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{RG, stl_pkg::CFG_SIGMA,     8'd255, 8'd0,  8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{RG, stl_pkg::CFG_HUE_PICK,  8'h80, 8'd0,   8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{RG, stl_pkg::CFG_SAT_PICK,  8'hFF, 8'd0,   8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd90,  8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd91,  8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{RG, CFG_SPARE_IDX,          8'h55, 8'd0,   8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd0,   8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{RG, stl_pkg::CFG_HUE_PICK,  8'h7F, 8'd0,   8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{RG, stl_pkg::CFG_SAT_PICK,  8'h00, 8'd0,   8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd91,  8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{PX, stl_pkg::CFG_HUE_PICK,  8'h00, 8'd90,  8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}}
    };

    skin_tone_likelihood u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_hue         (i_hue),
        .i_saturation  (i_saturation),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hue_dist_sq (o_hue_dist_sq),
        .o_sat_dist_sq (o_sat_dist_sq),
        .o_likelihood  (o_likelihood),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // exp(-f) for f in [0,1] in Q30, summed as an alternating series.
    function automatic t_u64 exp_neg_q30(t_u64 f);
        t_u64 plus_sum;
        t_u64 minus_sum;
        t_u64 term;
        t_u64 nn;
        plus_sum  = Q30_UNIT;
        minus_sum = 0;
        term      = Q30_UNIT;
        for (int n = 1; n <= 20; n++) begin
            nn   = t_u64'(n);
            term = (term * f + (nn << 29)) / (nn << 30);
            if (n % 2 == 1) begin
                minus_sum += term;
            end else begin
                plus_sum += term;
            end
        end
        return plus_sum - minus_sum;
    endfunction

    // Entry i is exp(-8*i/depth) in Q16: whole powers of exp(-1) times the fraction.
    task automatic build_exp_q16();
        t_u64 e_one;
        t_u64 arg;
        t_u64 whole;
        t_u64 power;
        e_one = exp_neg_q30(Q30_UNIT);
        for (int i = 0; i <= TABLE_DEPTH; i++) begin
            arg   = (t_u64'(i) << 33) / t_u64'(TABLE_DEPTH);
            whole = arg >> 30;
            power = Q30_UNIT;
            for (t_u64 j = 0; j < whole; j++) begin
                power = (power * e_one + (Q30_UNIT >> 1)) >> 30;
            end
            exp_q16[i] = (power * exp_neg_q30(arg & (Q30_UNIT - 1)) + (t_u64'(1) << 43)) >> 44;
        end
    endtask

    function automatic t_u64 sigma_recip(int sw);
        t_u64 den;
        den = 800 * t_u64'(sw) * t_u64'(sw);
        if (den == 0) begin
            return 0;
        end
        return ((t_u64'(TABLE_DEPTH) << 37) + den / 2) / den;
    endfunction

    function automatic t_skin_score predict_score(logic [7:0] hue, logic [7:0] sat);
        t_skin_score res;
        int          h;
        int          dh;
        int          ds;
        t_u64        d2;
        t_u64        s2;
        t_u64        q;
        t_u64        pos;
        t_u64        k;
        t_u64        fr;
        t_u64        drop;
        t_u64        v;
        t_u64        hsq;
        t_u64        ssq;
        t_u64        lik;
        h = int'(hue);
        if (h > 90) begin
            h = h - 180;
        end
        dh  = h - hue_ref;
        ds  = int'(sat) - sat_ref;
        d2  = t_u64'(dh * dh);
        s2  = t_u64'(ds * ds);
        hsq = (d2 + 2) >> 2;
        ssq = (s2 + 50) / 100;
        if (hsq > 255) begin
            hsq = 255;
        end
        if (ssq > 255) begin
            ssq = 255;
        end
        // 400 times the sum of the squared halved and tenth distances.
        q = 100 * d2 + 4 * s2;
        if (sigma_ref == 0) begin
            lik = (q == 0) ? 255 : 0;
        end else begin
            pos = (q * recip_ref + (t_u64'(1) << 23)) >> 24;
            k   = pos >> 16;
            if (k >= t_u64'(TABLE_DEPTH)) begin
                lik = 0;
            end else begin
                fr   = pos & 64'hFFFF;
                drop = (exp_q16[k] > exp_q16[k+1]) ? exp_q16[k] - exp_q16[k+1] : 0;
                v    = exp_q16[k] - ((drop * fr + 64'h8000) >> 16);
                lik  = (255 * v + 64'h8000) >> 16;
                if (lik > 255) begin
                    lik = 255;
                end
            end
        end
        res.hue_sq = hsq[7:0];
        res.sat_sq = ssq[7:0];
        res.lik    = lik[7:0];
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string field, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
        end
    endtask

    always @(posedge i_clk) begin : score_check
        t_typed_score row;
        t_skin_score  want;
        if (!i_rst_n) begin
            hue_ref   = 0;
            sat_ref   = int'(stl_pkg::SAT_PICK_RESET);
            sigma_ref = int'(stl_pkg::SIGMA_RESET);
            recip_ref = sigma_recip(sigma_ref);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    stl_pkg::CFG_HUE_PICK: begin
                        hue_ref = int'($signed(i_cfg_data));
                    end
                    stl_pkg::CFG_SAT_PICK: begin
                        sat_ref = int'(i_cfg_data);
                    end
                    stl_pkg::CFG_SIGMA: begin
                        sigma_ref = int'(i_cfg_data);
                        recip_ref = sigma_recip(sigma_ref);
                    end
                    default: begin
                    end
                endcase
            end
            if (i_valid && !o_stall) begin
                row = typed_rows.pop_front();
                if (row.known) begin
                    pending_scores.push_back(row.score);
                end else begin
                    pending_scores.push_back(predict_score(i_hue, i_saturation));
                end
            end
            if (o_valid && !i_stall) begin
                if (pending_scores.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = pending_scores.pop_front();
                    check_field("hue_dist_sq", o_hue_dist_sq, want.hue_sq);
                    check_field("sat_dist_sq", o_sat_dist_sq, want.sat_sq);
                    check_field("likelihood", o_likelihood, want.lik);
                end
            end
        end
    end

    // Result side: random stall, a long hold-off once, and none in quiet mode.
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_trigger && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (quiet_mode) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 32);
            end
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(negedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("FAIL");
        $finish;
    end

    task automatic send_pixel(logic [7:0] hue, logic [7:0] sat, bit known, t_skin_score score);
        t_typed_score row;
        bit           taken;
        if (!quiet_mode) begin
            while ($urandom_range(99) < 32) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        row.known = known;
        row.score = score;
        typed_rows.push_back(row);
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        // The request is taken at the next edge if the block is not stalling now.
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_scores.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int          hue_plan [5] = '{0, -90, 90, -128, 127};
        int          sat_plan [5] = '{128, 0, 255, 255, 0};
        int          sig_plan [5] = '{20, 1, 255, 0, 2};
        int          ph_hue;
        int          ph_sat;
        int          ph_sig;
        int          h;
        int          s;
        logic [7:0]  hue_v;
        logic [7:0]  sat_v;
        t_skin_score no_score;
        no_score     = '0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_hue        = '0;
        i_saturation = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        build_exp_q16();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_reg) begin
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_data);
            end else begin
                send_pixel(directed_rows[r].hue, directed_rows[r].sat,
                           directed_rows[r].known, directed_rows[r].score);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 5) begin
                ph_hue = hue_plan[ph];
                ph_sat = sat_plan[ph];
                ph_sig = sig_plan[ph];
            end else begin
                ph_hue = int'($urandom_range(180)) - 90;
                ph_sat = int'($urandom_range(255));
                ph_sig = ($urandom_range(1) == 1) ? int'($urandom_range(40, 1))
                                                  : int'($urandom_range(255, 1));
            end
            write_reg(stl_pkg::CFG_HUE_PICK, 8'(ph_hue));
            write_reg(stl_pkg::CFG_SAT_PICK, 8'(ph_sat));
            write_reg(stl_pkg::CFG_SIGMA, 8'(ph_sig));
            quiet_mode = (ph == 2);
            if (ph == 1) begin
                hold_trigger = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                if ($urandom_range(1) == 1) begin
                    // Close to the reference tone, so the likelihood covers its full range.
                    h = ph_hue + int'($urandom_range(40)) - 20;
                    s = ph_sat + int'($urandom_range(60)) - 30;
                    h = (h < -89) ? -89 : (h > 90) ? 90 : h;
                    s = (s < 0) ? 0 : (s > 255) ? 255 : s;
                    hue_v = (h < 0) ? 8'(h + 180) : 8'(h);
                    if (h >= 0 && h <= 75 && $urandom_range(9) == 0) begin
                        hue_v = 8'(h + 180);
                    end
                    sat_v = 8'(s);
                end else begin
                    hue_v = ($urandom_range(99) < 85) ? 8'($urandom_range(179))
                                                      : 8'($urandom_range(255, 180));
                    sat_v = 8'($urandom_range(255));
                end
                send_pixel(hue_v, sat_v, 1'b0, no_score);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_scores.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/stl_pkg.sv
rtl/stl_cfg.sv
rtl/stl_dist.sv
rtl/stl_scale.sv
rtl/stl_exp.sv
rtl/skin_tone_likelihood.sv
rtl/stl_chk.sv
test/tb_top.sv
